FILE: hdl/lpad_pkg.sv
// Package: field types, constants and GF(2^M) helpers for the point add/double block.
package lpad_pkg;

    localparam int FIELD_DEGREE = 63;
    localparam int FE_W         = FIELD_DEGREE;
    localparam int RED_N        = FIELD_DEGREE - 1;
    localparam int PROD_W       = 2 * FIELD_DEGREE - 1;
    localparam int REG_W        = 63;
    localparam int BUSY_W       = 6;
    localparam logic [BUSY_W-1:0] BUSY_LOAD = BUSY_W'(RED_N + 1);

    localparam logic       CFG_POLY  = 1'b0;
    localparam logic       CFG_A_ONE = 1'b1;
    localparam logic [REG_W-1:0] POLY_RESET = REG_W'(3);

    localparam int S_DATA_W = 384;
    localparam int M_DATA_W = 192;

    typedef logic [FE_W-1:0] t_fe;
    typedef logic [RED_N-1:0][FE_W-1:0] t_redtab;

    typedef enum logic [2:0] {
        MODE_DBL  = 3'b001,
        MODE_COPY = 3'b010,
        MODE_ADD  = 3'b100
    } t_mode;

    // Side data that rides along the pipeline.
    typedef struct packed {
        t_mode mode;
        logic  flag;
        t_fe   px;
        t_fe   pl;
        t_fe   pz;
        t_fe   qz;
        t_fe   dx;
        t_fe   dl;
        t_fe   dz;
        logic  dinf;
        logic  a0;
        logic  b0;
    } t_carry;

    // Multiply by x modulo the field polynomial.
    function automatic t_fe gf_xtime(t_fe v, t_fe plow);
        t_fe r;
        r = {v[FE_W-2:0], 1'b0};
        if (v[FE_W-1]) r = r ^ plow;
        return r;
    endfunction

    // Carry-less product, then fold the high half with x^(M+k) mod P.
    function automatic t_fe gf_mul(t_fe a, t_fe b, t_redtab rt);
        logic [PROD_W-1:0] p;
        t_fe               r;
        p = '0;
        for (int i = 0; i < FE_W; i++) begin
            if (b[i]) p = p ^ ({{(PROD_W-FE_W){1'b0}}, a} << i);
        end
        r = p[FE_W-1:0];
        for (int k = 0; k < RED_N; k++) begin
            if (p[FE_W+k]) r = r ^ rt[k];
        end
        return r;
    endfunction

endpackage

FILE: hdl/lambda_proj_point_add_double.sv
// Top level: pipelined lambda-projective point addition and doubling over GF(2^63).
//
// Usage: one request enters on the s_ stream (func on s_tuser, both points on
// s_tdata) and one result point leaves on the m_ stream. Curve settings come in
// on the plain write port (index 0: reduction polynomial low part, index 1:
// coefficient a is one).
// An accepted request passes five field-multiply stages (one GF(2^63) multiply
// with reduction per operand per stage) and the output register before m_tvalid.
// Throughput is one transaction per cycle while s_tready is high.
// The reduction table (x^(63+k) mod P, 62 rows) is rebuilt by a systolic shift
// after reset and after every polynomial write; s_tready stays low meanwhile.
// Reset is synchronous and active low: it clears valid bits, restores the
// polynomial to x^63 + x + 1 and a to one, and starts the table rebuild.
// When m_tready is low with a result waiting, the whole pipe holds in place and
// s_tready drops; nothing is lost or repeated.
module lambda_proj_point_add_double (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ax, ay, az, a_z_is_one, bx, by, bz, b_z_is_one, zero fill
    input  logic [lpad_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rx, ry, rz, r_z_is_one, zero fill
    output logic [lpad_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [lpad_pkg::REG_W-1:0]     i_cfg_data
);
    import lpad_pkg::*;

    // configuration and reduction table
    logic [REG_W-1:0]  r_plow;
    logic              r_a_one;
    t_redtab           r_red;
    logic [BUSY_W-1:0] r_busy;
    t_fe               w_plow;

    assign w_plow = r_plow[FE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plow  <= POLY_RESET;
            r_a_one <= 1'b1;
            r_busy  <= BUSY_LOAD;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_POLY) begin
                r_plow <= i_cfg_data;
                r_busy <= BUSY_LOAD;
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 1'b1;
            end
            if (i_cfg_we && i_cfg_idx == CFG_A_ONE) r_a_one <= i_cfg_data[0];
        end
    end

    // each row follows its predecessor times x
    always_ff @(posedge i_clk) begin
        r_red[0] <= w_plow;
        for (int k = 1; k < RED_N; k++) r_red[k] <= gf_xtime(r_red[k-1], w_plow);
    end

    // pipeline control: one enable for all stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic w_en, w_take;

    assign w_en     = !r_ov || m_tready;
    assign s_tready = w_en && (r_busy == '0);
    assign w_take   = s_tvalid && s_tready;
    assign m_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_take; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3;   r_v5 <= r_v4; r_ov <= r_v5;
        end
    end

    // stage 0: unpack and pick operands
    t_fe  w_ax, w_ay, w_az, w_bx, w_by, w_bz;
    logic w_af, w_bf;
    t_fe  w_px, w_pl, w_pz, w_qx, w_ql, w_qz, w_dx, w_dl, w_dz;
    t_mode w_mode;
    logic  w_flag;

    assign w_ax = s_tdata[62:0];
    assign w_ay = s_tdata[125:63];
    assign w_az = s_tdata[188:126];
    assign w_af = s_tdata[189];
    assign w_bx = s_tdata[252:190];
    assign w_by = s_tdata[315:253];
    assign w_bz = s_tdata[378:316];
    assign w_bf = s_tdata[379];

    always_comb begin
        w_mode = MODE_ADD; w_flag = 1'b0;
        w_px = w_ax; w_pl = w_ay; w_pz = w_az;
        w_qx = w_bx; w_ql = w_by; w_qz = w_bz;
        w_dx = w_ax; w_dl = w_ay; w_dz = w_az;
        if (s_tuser) begin
            w_mode = MODE_DBL;
        end else if (w_az == '0) begin
            // first point is infinity: copy the second one
            w_mode = MODE_COPY; w_flag = w_bf;
            w_px = w_bx; w_pl = w_by; w_pz = w_bz;
        end else if (w_bz == '0) begin
            w_mode = MODE_COPY; w_flag = w_af;
        end else if (w_bf) begin
            // mixed add: affine operand as Q with Z forced to one
            w_qz = FE_W'(1);
            w_dx = w_bx; w_dl = w_by; w_dz = w_bz;
        end else if (w_af) begin
            w_px = w_bx; w_pl = w_by; w_pz = w_bz;
            w_qx = w_ax; w_ql = w_ay; w_qz = FE_W'(1);
        end
    end

    // stage 1
    t_carry r1_c;
    t_fe    r1_pxq, r1_qxp, r1_m1, r1_m2, r1_lz, r1_zz, r1_xz, r1_ll;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_c.mode <= w_mode;
            r1_c.flag <= w_flag;
            r1_c.px   <= w_px;
            r1_c.pl   <= w_pl;
            r1_c.pz   <= w_pz;
            r1_c.qz   <= w_qz;
            r1_c.dx   <= '0;
            r1_c.dl   <= '0;
            r1_c.dz   <= '0;
            r1_c.dinf <= (w_dz == '0);
            r1_c.a0   <= 1'b0;
            r1_c.b0   <= 1'b0;
            r1_pxq    <= gf_mul(w_px, w_qz, r_red);
            r1_qxp    <= gf_mul(w_qx, w_pz, r_red);
            r1_m1     <= gf_mul(w_ql, w_pz, r_red);
            r1_m2     <= gf_mul(w_qz, w_pl, r_red);
            r1_lz     <= gf_mul(w_dz, w_dl, r_red);
            r1_zz     <= gf_mul(w_dz, w_dz, r_red);
            r1_xz     <= gf_mul(w_dx, w_dz, r_red);
            r1_ll     <= gf_mul(w_dl, w_dl, r_red);
        end
    end

    // stage 2: finish the double, start the add
    t_fe    w1_a, w1_b, w1_t, w1_dx, w1_dz;
    t_carry w1_c;
    t_carry r2_c;
    t_fe    r2_qa, r2_pa, r2_b2, r2_a;

    assign w1_a  = r1_m1 ^ r1_m2;
    assign w1_b  = r1_qxp ^ r1_pxq;
    assign w1_t  = r1_ll ^ r1_lz ^ (r_a_one ? r1_zz : '0);
    assign w1_dx = gf_mul(w1_t, w1_t, r_red);
    assign w1_dz = gf_mul(r1_zz, w1_t, r_red);

    always_comb begin
        w1_c    = r1_c;
        w1_c.dx = w1_dx;
        w1_c.dz = w1_dz;
        w1_c.dl = gf_mul(r1_xz, r1_xz, r_red) ^ gf_mul(r1_lz, w1_t, r_red)
                  ^ w1_dz ^ w1_dx;
        w1_c.a0 = (w1_a == '0);
        w1_c.b0 = (w1_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c    <= w1_c;
            r2_qa   <= gf_mul(r1_qxp, w1_a, r_red);
            r2_pa   <= gf_mul(r1_pxq, w1_a, r_red);
            r2_b2   <= gf_mul(w1_b, w1_b, r_red);
            r2_a    <= w1_a;
        end
    end

    // stage 3
    t_carry r3_c;
    t_fe    r3_rx, r3_u, r3_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_c  <= r2_c;
            r3_rx <= gf_mul(r2_qa, r2_pa, r_red);
            r3_u  <= gf_mul(r2_b2, r2_a, r_red);
            r3_v  <= gf_mul(r2_b2 ^ r2_qa, r2_b2 ^ r2_qa, r_red);
        end
    end

    // stage 4
    t_carry r4_c;
    t_fe    r4_rx, r4_v, r4_w;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_c  <= r3_c;
            r4_rx <= r3_rx;
            r4_v  <= r3_v;
            r4_w  <= gf_mul(r3_c.qz, r3_u, r_red);
        end
    end

    // stage 5
    t_carry r5_c;
    t_fe    r5_rx, r5_ry, r5_rz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_c  <= r4_c;
            r5_rx <= r4_rx;
            r5_ry <= gf_mul(r4_c.pz ^ r4_c.pl, r4_w, r_red) ^ r4_v;
            r5_rz <= gf_mul(r4_c.pz, r4_w, r_red);
        end
    end

    // result select into the output register
    t_fe  w_ox, w_oy, w_oz;
    logic w_of;
    logic w_use_dbl;

    always_comb begin
        w_ox = r5_rx; w_oy = r5_ry; w_oz = r5_rz; w_of = 1'b0;
        w_use_dbl = 1'b0;
        case (r5_c.mode)
            MODE_DBL: w_use_dbl = 1'b1;
            MODE_COPY: begin
                w_ox = r5_c.px; w_oy = r5_c.pl; w_oz = r5_c.pz; w_of = r5_c.flag;
            end
            MODE_ADD: begin
                if (r5_c.b0) begin
                    // equal points double, opposite points give infinity
                    w_use_dbl = r5_c.a0;
                    if (!r5_c.a0) begin
                        w_ox = '0; w_oy = '0; w_oz = '0;
                    end
                end
            end
            default: begin
                w_ox = '0; w_oy = '0; w_oz = '0;
            end
        endcase
        if (w_use_dbl) begin
            if (r5_c.dinf) begin
                w_ox = '0; w_oy = '0; w_oz = '0;
            end else begin
                w_ox = r5_c.dx; w_oy = r5_c.dl; w_oz = r5_c.dz;
            end
        end
    end

    logic [M_DATA_W-1:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (w_en) r_odata <= {{(M_DATA_W-3*FE_W-1){1'b0}}, w_of, w_oz, w_oy, w_ox};
    end

    assign m_tdata = r_odata;

    // checks
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy != '0) |-> !s_tready) else $error("input taken during table rebuild");

    a_poly_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_POLY) |=> (r_busy == BUSY_LOAD))
        else $error("polynomial write did not start rebuild");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_tready) |=> (r_ov && $stable(r_odata)))
        else $error("stalled result dropped or changed");

    a_flag_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r5_c.mode != MODE_COPY && w_en) |=> !r_odata[3*FE_W])
        else $error("affine flag set on computed result");

    a_stage_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(r_v1) && $stable(r_v5)))
        else $error("pipeline moved during stall");

endmodule
